>>> design/ami_pkg.sv
// Shared types and constants for the affine matrix inverse block.
// Used by every module of the block; it depends on nothing.
package ami_pkg;

  localparam int ROW_W = 2;

  localparam logic [ROW_W-1:0] ROW_FIRST    = 2'd0;
  localparam logic [ROW_W-1:0] ROW_LIN_LAST = 2'd2;
  localparam logic [ROW_W-1:0] ROW_TRANS    = 2'd3;

  // Control that travels with one row through the lanes.
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic             sing;
  } ctl_t;

  // Cofactor k of the adjugate is m[r1][c1]*m[r2][c2] - m[r1][c2]*m[r2][c1],
  // listed as {r1, c1, r2, c2} in row-major order of the adjugate.
  localparam logic [1:0] ADJ_IDX [9][4] = '{
    '{2'd1, 2'd1, 2'd2, 2'd2}, '{2'd0, 2'd2, 2'd2, 2'd1}, '{2'd0, 2'd1, 2'd1, 2'd2},
    '{2'd1, 2'd2, 2'd2, 2'd0}, '{2'd0, 2'd0, 2'd2, 2'd2}, '{2'd0, 2'd2, 2'd1, 2'd0},
    '{2'd1, 2'd0, 2'd2, 2'd1}, '{2'd0, 2'd1, 2'd2, 2'd0}, '{2'd0, 2'd0, 2'd1, 2'd1}
  };

endpackage

>>> design/ami_front.sv
// Front end: cofactors, determinant and the row issue sequencer.
// Depends on ami_pkg; feeds the three column lanes.
module ami_front #(
  parameter int W = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_acc,
  input  logic [12*W-1:0]         items,
  output ami_pkg::ctl_t           iss_ctl,
  output logic signed [2*W:0]     iss_adj [3],
  output logic signed [W-1:0]     iss_t,
  output logic [3*W+1:0]          iss_dmag,
  output logic                    iss_dneg
);

  localparam int PW   = 2 * W;
  localparam int CW   = 2 * W + 1;
  localparam int DETW = 3 * W + 3;
  localparam int DMW  = 3 * W + 2;

  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [W-1:0]  a0_r [3][3];
  logic signed [W-1:0]  t0_r [3], t1_r [3], t2_r [3], t3_r [3], t4_r [3], t5_r [3];
  logic signed [W-1:0]  r1_r [3], r2_r [3];
  logic signed [PW-1:0] p1_r [18];
  logic signed [CW-1:0] adj2_r [9], adj3_r [9], adj4_r [9], adj5_r [9];
  logic signed [CW-1:0] plo3_r [3], phi3_r [3];
  logic signed [DETW-1:0] det4_r;
  logic signed [DETW-1:0] det_abs;
  logic [DMW-1:0] dmag5_r;
  logic dneg5_r, sing5_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] iss_row;
  logic       iss_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      cnt_r <= 2'd0;
    end else if (adv) begin
      v0_r <= in_acc;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      cnt_r <= cnt_nxt;
    end
  end

  // Input capture, then the eighteen two-by-two products.
  always_ff @(posedge clk) begin
    if (adv && in_acc) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          a0_r[i][j] <= items[(i*3+j)*W +: W];
        end
        t0_r[i] <= items[(9+i)*W +: W];
      end
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_cof
    always_ff @(posedge clk) begin
      if (adv && v0_r) begin
        p1_r[2*k] <= PW'(a0_r[ami_pkg::ADJ_IDX[k][0]][ami_pkg::ADJ_IDX[k][1]])
                   * PW'(a0_r[ami_pkg::ADJ_IDX[k][2]][ami_pkg::ADJ_IDX[k][3]]);
        p1_r[2*k+1] <= PW'(a0_r[ami_pkg::ADJ_IDX[k][0]][ami_pkg::ADJ_IDX[k][3]])
                     * PW'(a0_r[ami_pkg::ADJ_IDX[k][2]][ami_pkg::ADJ_IDX[k][1]]);
      end
      if (adv && v1_r) begin
        adj2_r[k] <= CW'(p1_r[2*k]) - CW'(p1_r[2*k+1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v0_r) begin
      t1_r <= t0_r;
      r1_r <= a0_r[0];
    end
    if (adv && v1_r) begin
      t2_r <= t1_r;
      r2_r <= r1_r;
    end
    if (adv && v2_r) begin
      t3_r <= t2_r;
      adj3_r <= adj2_r;
      // Row 0 times the first adjugate column, the cofactor split in halves.
      for (int j = 0; j < 3; j++) begin
        plo3_r[j] <= CW'(r2_r[j]) * $signed({1'b0, adj2_r[3*j][W-1:0]});
        phi3_r[j] <= CW'(r2_r[j]) * CW'($signed(adj2_r[3*j][CW-1:W]));
      end
    end
    if (adv && v3_r) begin
      t4_r <= t3_r;
      adj4_r <= adj3_r;
      det4_r <= (DETW'(phi3_r[0]) <<< W) + DETW'(plo3_r[0])
              + (DETW'(phi3_r[1]) <<< W) + DETW'(plo3_r[1])
              + (DETW'(phi3_r[2]) <<< W) + DETW'(plo3_r[2]);
    end
    if (adv && v4_r) begin
      t5_r <= t4_r;
      adj5_r <= adj4_r;
      dmag5_r <= det_abs[DMW-1:0];
      dneg5_r <= det4_r[DETW-1];
      sing5_r <= (det4_r == '0);
    end
  end

  assign det_abs = det4_r[DETW-1] ? -det4_r : det4_r;

  // The three linear rows leave one after another in row order; a stall holds them.
  always_comb begin
    iss_valid = v5_r || (cnt_r != 2'd0);
    iss_row   = v5_r ? ami_pkg::ROW_FIRST : cnt_r;
    cnt_nxt   = (iss_valid && iss_row != ami_pkg::ROW_LIN_LAST) ? iss_row + 2'd1 : 2'd0;
    case (iss_row)
      2'd0: begin
        iss_adj = '{adj5_r[0], adj5_r[1], adj5_r[2]};
        iss_t   = t5_r[0];
      end
      2'd1: begin
        iss_adj = '{adj5_r[3], adj5_r[4], adj5_r[5]};
        iss_t   = t5_r[1];
      end
      default: begin
        iss_adj = '{adj5_r[6], adj5_r[7], adj5_r[8]};
        iss_t   = t5_r[2];
      end
    endcase
  end

  assign iss_ctl  = '{valid: iss_valid, row: iss_row, sing: sing5_r};
  assign iss_dmag = dmag5_r;
  assign iss_dneg = dneg5_r;

endmodule

>>> design/ami_lane.sv
// One column lane: pipelined rounding divider and translation accumulator.
// Depends on ami_pkg; three copies sit between the front end and the merge.
module ami_lane #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  ami_pkg::ctl_t        in_ctl,
  input  logic signed [2*W:0]  in_adj,
  input  logic signed [W-1:0]  in_t,
  input  logic [3*W+1:0]       in_dmag,
  input  logic                 in_dneg,
  output ami_pkg::ctl_t        lin_ctl,
  output logic [W-1:0]         lin_elem,
  output logic                 tr_valid,
  output logic                 tr_sing,
  output logic [W-1:0]         tr_elem
);

  localparam int PW  = 2 * W;
  localparam int CW  = 2 * W + 1;
  localparam int DMW = 3 * W + 2;
  localparam int RW  = 4 * W + 2 * F + 4;
  localparam int AW  = 2 * W + 2;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [AW-1:0] HALF = AW'(1) << (F - 1);

  ami_pkg::ctl_t ctl_a_r, ctl_b_r, ctl_e_r, ctl_m_r;
  logic [PW-1:0]  cm_a_r;
  logic [DMW-1:0] dm_a_r;
  logic           neg_a_r, neg_b_r;
  logic signed [W-1:0] t_a_r, t_b_r, t_e_r;
  logic signed [CW-1:0] adj_abs;
  logic [RW-1:0]  num_b_r, den_b_r;

  // Divider pipeline; index 0 is the overflow check stage.
  ami_pkg::ctl_t ctl_p [W+1];
  logic [RW-1:0] rem_p [W+1];
  logic [RW-1:0] den_p [W+1];
  logic [W-1:0]  q_p   [W+1];
  logic          neg_p [W+1];
  logic          ovf_p [W+1];
  logic signed [W-1:0] t_p [W+1];

  logic [W-1:0]  elem_e_r;
  logic [W-1:0]  elem_nxt;
  logic signed [PW-1:0] prod_m_r;
  logic signed [AW-1:0] acc_r;
  logic          accv_r, acc_sing_r;
  logic          f1v_r, f1_sing_r, f1_neg_r;
  logic [AW-1:0] f1_mag_r;
  logic signed [AW-1:0] acc_abs;
  logic [AW-1:0] rnd;
  logic          rnd_sat;
  logic          f2v_r, f2_sing_r;
  logic [W-1:0]  f2_elem_r, tr_nxt;

  assign adj_abs = in_adj[CW-1] ? -in_adj : in_adj;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r.valid <= 1'b0;
      ctl_b_r.valid <= 1'b0;
      ctl_p[0].valid <= 1'b0;
    end else if (adv) begin
      ctl_a_r.valid <= in_ctl.valid;
      ctl_b_r.valid <= ctl_a_r.valid;
      ctl_p[0].valid <= ctl_b_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_a_r.row  <= in_ctl.row;
      ctl_a_r.sing <= in_ctl.sing;
      cm_a_r  <= adj_abs[PW-1:0];
      dm_a_r  <= in_dmag;
      neg_a_r <= in_adj[CW-1] ^ in_dneg;
      t_a_r   <= in_t;

      ctl_b_r.row  <= ctl_a_r.row;
      ctl_b_r.sing <= ctl_a_r.sing;
      // Rounded quotient: floor((2N + D) / 2D) with N = |C| * 2^(2F).
      num_b_r <= (RW'(cm_a_r) << (2 * F + 1)) + RW'(dm_a_r);
      den_b_r <= RW'(dm_a_r) << 1;
      neg_b_r <= neg_a_r;
      t_b_r   <= t_a_r;

      ctl_p[0].row  <= ctl_b_r.row;
      ctl_p[0].sing <= ctl_b_r.sing;
      rem_p[0] <= num_b_r;
      den_p[0] <= den_b_r;
      q_p[0]   <= '0;
      neg_p[0] <= neg_b_r;
      ovf_p[0] <= (num_b_r >= (den_b_r << W));
      t_p[0]   <= t_b_r;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 0; s < W; s++) begin : g_div
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = den_p[s] << (W - 1 - s);
    assign ge  = (rem_p[s] >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_p[s+1].valid <= 1'b0;
      end else if (adv) begin
        ctl_p[s+1].valid <= ctl_p[s].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ctl_p[s+1].row  <= ctl_p[s].row;
        ctl_p[s+1].sing <= ctl_p[s].sing;
        rem_p[s+1] <= ge ? rem_p[s] - dsh : rem_p[s];
        den_p[s+1] <= den_p[s];
        q_p[s+1]   <= q_p[s] | (W'(ge) << (W - 1 - s));
        neg_p[s+1] <= neg_p[s];
        ovf_p[s+1] <= ovf_p[s];
        t_p[s+1]   <= t_p[s];
      end
    end
  end

  always_comb begin
    if (ctl_p[W].sing) begin
      elem_nxt = '0;
    end else if (ovf_p[W] || q_p[W][W-1]) begin
      elem_nxt = neg_p[W] ? MINV : MAXV;
    end else begin
      elem_nxt = neg_p[W] ? -q_p[W] : q_p[W];
    end
  end

  assign acc_abs = acc_r[AW-1] ? -acc_r : acc_r;
  assign rnd     = (f1_mag_r + HALF) >> F;
  assign rnd_sat = |rnd[AW-1:W-1];

  always_comb begin
    if (f1_sing_r) begin
      tr_nxt = '0;
    end else if (f1_neg_r) begin
      tr_nxt = rnd_sat ? MAXV : rnd[W-1:0];
    end else begin
      tr_nxt = rnd_sat ? MINV : -rnd[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_e_r.valid <= 1'b0;
      ctl_m_r.valid <= 1'b0;
      accv_r <= 1'b0;
      f1v_r  <= 1'b0;
      f2v_r  <= 1'b0;
    end else if (adv) begin
      ctl_e_r.valid <= ctl_p[W].valid;
      ctl_m_r.valid <= ctl_e_r.valid;
      accv_r <= ctl_m_r.valid && (ctl_m_r.row == ami_pkg::ROW_LIN_LAST);
      f1v_r  <= accv_r;
      f2v_r  <= f1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_e_r.row  <= ctl_p[W].row;
      ctl_e_r.sing <= ctl_p[W].sing;
      elem_e_r <= elem_nxt;
      t_e_r    <= t_p[W];

      ctl_m_r.row  <= ctl_e_r.row;
      ctl_m_r.sing <= ctl_e_r.sing;
      prod_m_r <= PW'(t_e_r) * PW'($signed(elem_e_r));

      if (ctl_m_r.valid) begin
        acc_r <= (ctl_m_r.row == ami_pkg::ROW_FIRST) ? AW'(prod_m_r)
                                                     : acc_r + AW'(prod_m_r);
        acc_sing_r <= ctl_m_r.sing;
      end

      f1_mag_r  <= acc_abs;
      f1_neg_r  <= acc_r[AW-1];
      f1_sing_r <= acc_sing_r;

      f2_elem_r <= tr_nxt;
      f2_sing_r <= f1_sing_r;
    end
  end

  assign lin_ctl  = ctl_e_r;
  assign lin_elem = elem_e_r;
  assign tr_valid = f2v_r;
  assign tr_sing  = f2_sing_r;
  assign tr_elem  = f2_elem_r;

endmodule

>>> design/ami_merge.sv
// Merging stage: lines up the linear rows and the translation row of the lanes
// into one output register. Depends on ami_pkg.
module ami_merge #(
  parameter int W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ami_pkg::ctl_t    lin_ctl,
  input  logic [3*W-1:0]   lin_row,
  input  logic             tr_valid,
  input  logic             tr_sing,
  input  logic [3*W-1:0]   tr_row,
  input  logic             out_ready,
  output logic             adv,
  output logic             out_valid,
  output ami_pkg::ctl_t    out_ctl,
  output logic [3*W-1:0]   out_row
);

  localparam int DLY = 3;

  ami_pkg::ctl_t  d_ctl_r [DLY];
  logic [3*W-1:0] d_row_r [DLY];
  ami_pkg::ctl_t  o_ctl_r;
  logic [3*W-1:0] o_row_r;

  assign adv = !o_ctl_r.valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DLY; i++) begin
        d_ctl_r[i].valid <= 1'b0;
      end
      o_ctl_r.valid <= 1'b0;
    end else if (adv) begin
      d_ctl_r[0].valid <= lin_ctl.valid;
      for (int i = 1; i < DLY; i++) begin
        d_ctl_r[i].valid <= d_ctl_r[i-1].valid;
      end
      o_ctl_r.valid <= d_ctl_r[DLY-1].valid || tr_valid;
    end
  end

  // The linear rows wait until the translation row of the same matrix is
  // close behind, so the two sources never hit the output in one cycle.
  always_ff @(posedge clk) begin
    if (adv) begin
      d_ctl_r[0].row  <= lin_ctl.row;
      d_ctl_r[0].sing <= lin_ctl.sing;
      d_row_r[0]      <= lin_row;
      for (int i = 1; i < DLY; i++) begin
        d_ctl_r[i].row  <= d_ctl_r[i-1].row;
        d_ctl_r[i].sing <= d_ctl_r[i-1].sing;
        d_row_r[i]      <= d_row_r[i-1];
      end
      if (tr_valid) begin
        o_ctl_r.row  <= ami_pkg::ROW_TRANS;
        o_ctl_r.sing <= tr_sing;
        o_row_r      <= tr_row;
      end else begin
        o_ctl_r.row  <= d_ctl_r[DLY-1].row;
        o_ctl_r.sing <= d_ctl_r[DLY-1].sing;
        o_row_r      <= d_row_r[DLY-1];
      end
    end
  end

  assign out_valid = o_ctl_r.valid;
  assign out_ctl   = o_ctl_r;
  assign out_row   = o_row_r;

endmodule

>>> design/affine_matrix_inverse_core.sv
// Top level of the affine 4x3 inverse: front end, three column lanes, merge.
// Depends on ami_pkg, ami_front, ami_lane and ami_merge.
//
// Usage. One input transaction carries an affine transform: nine entries of
// the 3x3 linear part, row-major, then the translation x, y, z, all signed
// fixed point. The block answers with four output transactions: the three
// rows of the inverted linear part (adjugate over determinant, rounded to
// nearest with ties away from zero and saturated), then the translation row,
// which is minus the translation times the inverted part and carries tlast.
// A zero determinant flags all four rows singular and zeroes their elements.
// The four result rows share the single output register, so after each
// accepted transaction the input is held not ready until the gap counter
// has run down. The first row's delay to the output register is set by the
// restoring divider in each lane, which resolves one quotient bit per stage;
// the other rows follow it in order.
// One lane per column; its divider accepts one row per cycle unless stalled.
// Reset clears every valid bit; the pipeline is empty afterwards.
// When the receiver stalls, the whole pipeline holds in place, and in_tready
// drops until the pending row is taken.
module affine_matrix_inverse_core #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2, shift_x, shift_y,
  // shift_z, then zero fill.
  input  logic [((12*WORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // col_a, col_b, col_c, then zero fill.
  output logic [((3*WORD_BITS+7)/8)*8-1:0] out_tdata,
  // row_index (2 bits), singular.
  output logic [2:0] out_tuser,
  output logic out_tlast
);

  localparam int W    = WORD_BITS;
  localparam int OUTW = ((3 * W + 7) / 8) * 8;

  logic adv, in_acc;
  logic [1:0] gap_r;

  ami_pkg::ctl_t         iss_ctl;
  logic signed [2*W:0]   iss_adj [3];
  logic signed [W-1:0]   iss_t;
  logic [3*W+1:0]        iss_dmag;
  logic                  iss_dneg;

  ami_pkg::ctl_t  lin_ctl [3];
  logic [W-1:0]   lin_elem [3];
  logic           tr_valid [3];
  logic           tr_sing  [3];
  logic [W-1:0]   tr_elem  [3];

  ami_pkg::ctl_t  out_ctl;
  logic [3*W-1:0] out_row;

  // Items are spaced apart by the gap counter so their rows never overlap.
  assign in_tready = adv && (gap_r == 2'd0);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= 2'd0;
    end else if (adv) begin
      if (in_acc) begin
        gap_r <= 2'd3;
      end else if (gap_r != 2'd0) begin
        gap_r <= gap_r - 2'd1;
      end
    end
  end

  ami_front #(.W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_acc   (in_acc),
    .items    (in_tdata[12*W-1:0]),
    .iss_ctl  (iss_ctl),
    .iss_adj  (iss_adj),
    .iss_t    (iss_t),
    .iss_dmag (iss_dmag),
    .iss_dneg (iss_dneg)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ami_lane #(.W(W), .F(FRAC_BITS)) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_ctl   (iss_ctl),
      .in_adj   (iss_adj[i]),
      .in_t     (iss_t),
      .in_dmag  (iss_dmag),
      .in_dneg  (iss_dneg),
      .lin_ctl  (lin_ctl[i]),
      .lin_elem (lin_elem[i]),
      .tr_valid (tr_valid[i]),
      .tr_sing  (tr_sing[i]),
      .tr_elem  (tr_elem[i])
    );
  end

  // All lanes run in lock step, so lane 0 speaks for the control.
  ami_merge #(.W(W)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .lin_ctl   (lin_ctl[0]),
    .lin_row   ({lin_elem[2], lin_elem[1], lin_elem[0]}),
    .tr_valid  (tr_valid[0]),
    .tr_sing   (tr_sing[0]),
    .tr_row    ({tr_elem[2], tr_elem[1], tr_elem[0]}),
    .out_ready (out_tready),
    .adv       (adv),
    .out_valid (out_tvalid),
    .out_ctl   (out_ctl),
    .out_row   (out_row)
  );

  assign out_tdata = OUTW'(out_row);
  assign out_tuser = {out_ctl.sing, out_ctl.row};
  assign out_tlast = (out_ctl.row == ami_pkg::ROW_TRANS);

endmodule

>>> dv/tb_affine_matrix_inverse_core.sv
// Self-checking testbench for affine_matrix_inverse_core: drives affine transforms,
// predicts the four inverse rows of each one and checks every output row.
// Depends on ami_pkg and the affine_matrix_inverse_core RTL.
module tb_affine_matrix_inverse_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WB = 32;
  localparam int FB = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_ITEMS = 460;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [WB-1:0] word_t;
  typedef word_t xform_t [12];

  // One expected output row of the inverse.
  typedef struct {
    logic [ami_pkg::ROW_W-1:0] row;
    word_t            col_a;
    word_t            col_b;
    word_t            col_c;
    logic             sing;
    logic             last;
  } inv_row_t;

  // Scoreboard: holds the rows predicted for every accepted transform and
  // compares them, oldest first, against the rows the block produces.
  class inverse_scoreboard;
    inv_row_t pending_rows[$];
    int       errors;
    int       rows_checked;
    int       singular_seen;

    function new();
      errors = 0;
      rows_checked = 0;
      singular_seen = 0;
    endfunction

    task report(string what, logic [127:0] got, logic [127:0] want);
      errors++;
      $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    static function word_t saturate(wide_t v);
      wide_t hi;
      wide_t lo;
      hi = (wide_t'(1) <<< (WB - 1)) - 1;
      lo = -(wide_t'(1) <<< (WB - 1));
      if (v > hi) return word_t'(hi[WB-1:0]);
      if (v < lo) return word_t'(lo[WB-1:0]);
      return v[WB-1:0];
    endfunction

    // Quotient n / d rounded to nearest with ties away from zero; d != 0.
    static function wide_t round_div(wide_t n, wide_t d);
      wide_t nm;
      wide_t dm;
      wide_t q;
      nm = (n < 0) ? -n : n;
      dm = (d < 0) ? -d : d;
      q = (2 * nm + dm) / (2 * dm);
      return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    // Computes the four rows for one transform and queues them.
    function void note_input(xform_t x);
      wide_t    a [3][3];
      wide_t    cof [9];
      wide_t    det;
      wide_t    acc;
      word_t    inv [3][3];
      word_t    trans [3];
      inv_row_t r;
      logic     sing;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          a[i][j] = x[i*3+j];
      for (int k = 0; k < 9; k++)
        cof[k] = a[ami_pkg::ADJ_IDX[k][0]][ami_pkg::ADJ_IDX[k][1]]
               * a[ami_pkg::ADJ_IDX[k][2]][ami_pkg::ADJ_IDX[k][3]]
               - a[ami_pkg::ADJ_IDX[k][0]][ami_pkg::ADJ_IDX[k][3]]
               * a[ami_pkg::ADJ_IDX[k][2]][ami_pkg::ADJ_IDX[k][1]];
      det = a[0][0] * cof[0] + a[0][1] * cof[3] + a[0][2] * cof[6];
      sing = (det == 0);
      for (int k = 0; k < 9; k++) inv[k/3][k%3] = '0;
      for (int i = 0; i < 3; i++) trans[i] = '0;
      if (!sing) begin
        for (int k = 0; k < 9; k++)
          inv[k/3][k%3] = saturate(round_div(cof[k] <<< (2 * FB), det));
        // The translation row uses the already rounded linear elements.
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int j = 0; j < 3; j++) acc += wide_t'(x[9+j]) * wide_t'(inv[j][i]);
          trans[i] = saturate(round_div(-acc, wide_t'(1) <<< FB));
        end
      end
      if (sing) singular_seen++;
      for (int k = 0; k < 4; k++) begin
        r.row = k[ami_pkg::ROW_W-1:0];
        r.col_a = (k == 3) ? trans[0] : inv[k][0];
        r.col_b = (k == 3) ? trans[1] : inv[k][1];
        r.col_c = (k == 3) ? trans[2] : inv[k][2];
        r.sing = sing;
        r.last = (k == 3);
        pending_rows.push_back(r);
      end
    endfunction

    task check_result(logic [3*WB-1:0] data, logic [2:0] user, logic last);
      inv_row_t w;
      if (pending_rows.size() == 0) begin
        report("unexpected row", {user, data}, '0);
        return;
      end
      w = pending_rows.pop_front();
      rows_checked++;
      if (user[1:0] !== w.row) report("row_index", user[1:0], w.row);
      if (user[2] !== w.sing) report("singular", user[2], w.sing);
      if (last !== w.last) report("tlast", last, w.last);
      if (data[0 +: WB] !== w.col_a) report("col_a", data[0 +: WB], w.col_a);
      if (data[WB +: WB] !== w.col_b) report("col_b", data[WB +: WB], w.col_b);
      if (data[2*WB +: WB] !== w.col_c) report("col_c", data[2*WB +: WB], w.col_c);
    endtask
  endclass

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_tvalid = 0;
  logic                in_tready;
  logic [12*WB-1:0]    in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 0;
  logic [3*WB-1:0]     out_tdata;
  logic [2:0]          out_tuser;
  logic                out_tlast;

  inverse_scoreboard sb = new();
  bit  no_idle = 0;     // when set, neither side inserts wait cycles
  bit  hold_output = 0; // requests one long receiver stall
  int  matrices_sent = 0;
  int  idle_cycles = 0;

  affine_matrix_inverse_core #(.WORD_BITS(WB), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Watchdog: ends the run if no transaction happens for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d rows still pending", sb.pending_rows.size());
      $display("tb_affine_matrix_inverse_core NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: waits a random number of cycles before each row, and once
  // holds off for a long stretch so that the pipeline backs up.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (hold_output) begin
        gap = LONG_HOLD;
        hold_output = 0;
      end
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  // Offers one transform after a random gap and returns once it is accepted.
  task send_xform(xform_t x);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    for (int k = 0; k < 12; k++) in_tdata[k*WB +: WB] <= x[k];
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(x);
    matrices_sent++;
  endtask

  function automatic word_t q16(int whole);
    return word_t'(whole) <<< FB;
  endfunction

  function automatic word_t rand_small(int span);
    return word_t'($urandom_range(0, 2 * span)) - word_t'(span);
  endfunction

  // Random transform; most are well conditioned, some singular, some near
  // singular or full width so that the quotients saturate.
  function automatic xform_t rand_xform();
    xform_t x;
    int     mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 12; k++) begin
      case (mode)
        0, 1: x[k] = $urandom();
        2, 3, 4, 5: x[k] = rand_small(1 << (FB + 2));
        6: x[k] = rand_small(300);
        default: x[k] = rand_small(1 << (FB + 4));
      endcase
      if (k >= 9 && $urandom_range(0, 2) == 0) x[k] = $urandom();
    end
    if (mode == 7) begin
      // Diagonal linear part.
      for (int k = 0; k < 9; k++) if (k % 4 != 0) x[k] = '0;
    end else if (mode >= 8) begin
      // Singular: one row copies another or a column is zero.
      if ($urandom_range(0, 1)) begin
        for (int j = 0; j < 3; j++) x[6+j] = x[j];
      end else begin
        for (int i = 0; i < 3; i++) x[i*3+1] = '0;
      end
    end
    return x;
  endfunction

  initial begin
    xform_t x;
    word_t  wmax;
    word_t  wmin;
    wmax = {1'b0, {(WB-1){1'b1}}};
    wmin = {1'b1, {(WB-1){1'b0}}};
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Identity with a translation.
    x = '{q16(1), 0, 0, 0, q16(1), 0, 0, 0, q16(1), q16(3), q16(-2), q16(7)};
    send_xform(x);
    // All zeros is singular.
    foreach (x[k]) x[k] = '0;
    send_xform(x);
    // Scaled diagonal with extreme translation.
    x = '{q16(2), 0, 0, 0, q16(-4), 0, 0, 0, q16(8), wmax, wmin, wmax};
    send_xform(x);
    // Tiny diagonal: the inverse overflows and saturates both ways.
    x = '{1, 0, 0, 0, -1, 0, 0, 0, 1, q16(5), q16(5), q16(5)};
    send_xform(x);
    // Largest and smallest words everywhere.
    foreach (x[k]) x[k] = wmax;
    send_xform(x);
    foreach (x[k]) x[k] = wmin;
    send_xform(x);
    x = '{wmax, wmin, 0, wmin, wmax, wmin, 0, wmin, wmax, wmin, wmax, wmin};
    send_xform(x);
    x = '{wmin, 0, 0, 0, wmin, 0, 0, 0, wmin, wmax, wmax, wmax};
    send_xform(x);
    // Rounding: thirds in raw and whole units with odd raw translations.
    x = '{3, 0, 0, 0, q16(3), 0, 0, 0, q16(-3), 1, -1, q16(1)};
    send_xform(x);
    // Permutation and a rotation-like matrix.
    x = '{0, q16(1), 0, 0, 0, q16(1), q16(1), 0, 0, q16(1), q16(2), q16(3)};
    send_xform(x);
    x = '{q16(3) / 5, -q16(4) / 5, 0, q16(4) / 5, q16(3) / 5, 0, 0, 0, q16(1),
          -q16(10), q16(20), -q16(30)};
    send_xform(x);
    // Singular with duplicate rows, and all ones bits.
    x = '{q16(1), q16(2), q16(3), q16(1), q16(2), q16(3), q16(4), q16(5), q16(6),
          q16(1), q16(1), q16(1)};
    send_xform(x);
    foreach (x[k]) x[k] = '1;
    send_xform(x);

    // Random part: alternating stretches with and without idling, one long
    // receiver stall, and one pause until the block has drained.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = ((n / 40) % 3 == 1);
      if (n == 150) hold_output = 1;
      if (n == 300) begin
        in_tvalid <= 0;
        while (sb.pending_rows.size() != 0) @(posedge clk);
      end
      send_xform(rand_xform());
    end
    in_tvalid <= 0;
    no_idle = 0;

    while (sb.pending_rows.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Covered %0d transforms (%0d singular), %0d result rows checked.",
             matrices_sent, sb.singular_seen, sb.rows_checked);
    if (sb.errors == 0) begin
      $display("tb_affine_matrix_inverse_core OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb_affine_matrix_inverse_core NOT OK");
    end
    $finish;
  end
endmodule

>>> sim.f
design/ami_pkg.sv
design/ami_front.sv
design/ami_lane.sv
design/ami_merge.sv
design/affine_matrix_inverse_core.sv
dv/tb_affine_matrix_inverse_core.sv
